### sv/ffba_pkg.sv
package ffba_pkg;

  localparam int HEAP_GRANULES_DEF = 4096;

  // Payload widths fixed by the stream fields
  localparam int BYTE_W  = 16;
  localparam int GRAN_W  = 12;           // granule number carried in a 16-bit byte address
  localparam int NEED_W  = 13;           // ceil((65535 + 17) / 16) fits in 13 bits
  localparam int REQ_OVERHEAD  = 17;
  localparam int GRANULE_BYTES = 16;
  localparam int NEED_BIAS     = REQ_OVERHEAD + GRANULE_BYTES - 1;

  localparam int STEP_W = 4;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_NULL = 2'd1,
    ST_OOM  = 2'd2
  } status_e;

  typedef enum logic [STEP_W-1:0] {
    S_IDLE     = 4'd0,
    S_DISPATCH = 4'd1,
    S_CHECK    = 4'd2,
    S_INIT     = 4'd3,
    S_READ     = 4'd4,
    S_TEST     = 4'd5,
    S_HEAD     = 4'd6,
    S_REST     = 4'd7,
    S_FREE_PTR = 4'd8,
    S_FREE_RD  = 4'd9,
    S_FREE_WR  = 4'd10,
    S_FREE_ACK = 4'd11,
    S_NULL     = 4'd12,
    S_OOM      = 4'd13
  } step_e;

  typedef enum logic [3:0] {
    A_NONE,
    A_ACCEPT,
    A_PTR_CLEAR,
    A_READ,
    A_STEP,
    A_WR_HEAD,
    A_WR_REST,
    A_FREE_PTR,
    A_FREE_WR,
    A_PUSH_DONE,
    A_PUSH_NULL,
    A_PUSH_OOM
  } act_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_TXN,
    C_IS_FREE,
    C_REQ_ZERO,
    C_PAST_END,
    C_NO_FIT,
    C_FREE_BAD
  } cond_e;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_e target;
  } uword_t;

  // Control store: when cond holds jump to target, otherwise fall through
  function automatic uword_t ucode(step_e s);
    uword_t w;
    unique case (s)
      S_IDLE:     w = '{act: A_ACCEPT,    cond: C_NO_TXN,   target: S_IDLE};
      S_DISPATCH: w = '{act: A_NONE,      cond: C_IS_FREE,  target: S_FREE_PTR};
      S_CHECK:    w = '{act: A_NONE,      cond: C_REQ_ZERO, target: S_NULL};
      S_INIT:     w = '{act: A_PTR_CLEAR, cond: C_NEVER,    target: S_IDLE};
      S_READ:     w = '{act: A_READ,      cond: C_PAST_END, target: S_OOM};
      S_TEST:     w = '{act: A_STEP,      cond: C_NO_FIT,   target: S_READ};
      S_HEAD:     w = '{act: A_WR_HEAD,   cond: C_NEVER,    target: S_IDLE};
      S_REST:     w = '{act: A_WR_REST,   cond: C_ALWAYS,   target: S_IDLE};
      S_FREE_PTR: w = '{act: A_FREE_PTR,  cond: C_FREE_BAD, target: S_FREE_ACK};
      S_FREE_RD:  w = '{act: A_READ,      cond: C_NEVER,    target: S_IDLE};
      S_FREE_WR:  w = '{act: A_FREE_WR,   cond: C_ALWAYS,   target: S_IDLE};
      S_FREE_ACK: w = '{act: A_PUSH_DONE, cond: C_ALWAYS,   target: S_IDLE};
      S_NULL:     w = '{act: A_PUSH_NULL, cond: C_ALWAYS,   target: S_IDLE};
      S_OOM:      w = '{act: A_PUSH_OOM,  cond: C_ALWAYS,   target: S_IDLE};
      default:    w = '{act: A_NONE,      cond: C_ALWAYS,   target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

### sv/first_fit_block_allocator_core.sv
// First-fit allocator over a heap of HEAP_GRANULES 16-byte granules, run by a
// small microcoded sequencer over one single-port header memory. A transaction
// on the s_ side is an allocate (tuser 0) or a free (tuser 1); each yields one
// result transaction on the m_ side, held in an output register so the next
// request can be taken while the result waits. A free whose header would lie
// before or past the heap is dropped and only acknowledged; a zero-size
// allocate returns null; an allocate walks the headers up to the first one
// that fits, and returns out-of-memory once the walk passes the heap end.
// A result step waits while the output register still holds an untaken
// result. Each header visited takes a read step and a test step, because
// each header is one registered read of the memory port.
// No clearing pass after reset: only the first header carries a reset value.
module first_fit_block_allocator_core
  import ffba_pkg::*;
#(
  parameter int HEAP_GRANULES = HEAP_GRANULES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,   // [15:0] request_bytes, [31:16] payload_address
  input  logic        s_tuser_i,   // [0] kind
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [23:0] m_tdata_o    // [15:0] result_address, [17:16] status, rest zero
);

  localparam int AW = $clog2(HEAP_GRANULES);
  localparam int SW = AW + 1;               // block size in granules
  localparam int HW = SW + 1;               // size plus allocated bit
  localparam int PW = AW + 2;               // walk pointer may run up to twice the heap
  localparam int CW = (PW > NEED_W) ? PW : NEED_W;

  localparam logic [HW-1:0] HdrInit = {SW'(HEAP_GRANULES), 1'b0};
  localparam logic [CW-1:0] HeapEnd = CW'(HEAP_GRANULES);

  logic [HW-1:0] mem [HEAP_GRANULES];

  step_e  step_q, step_d;
  uword_t uw;

  logic              kind_q;
  logic [BYTE_W-1:0] req_q, addr_q;
  logic [NEED_W-1:0] need_q;
  logic [CW-1:0]     p_q;
  logic [HW-1:0]     rd_q;
  logic              rd_init_q;
  logic              hdr0_q;

  logic              out_valid_q;
  logic [BYTE_W-1:0] out_addr_q;
  status_e           out_status_q;

  logic              s_txn, out_full, is_push, stall, take;
  logic [HW-1:0]     hdr;
  logic [SW-1:0]     hdr_size;
  logic              hdr_alloc;
  logic [CW-1:0]     size_c, need_c, step_amt, rest_ptr, diff, p_inc, free_idx;
  logic              fit, past_end, rest_ok, free_bad;
  logic [BYTE_W:0]   need_sum;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr;
  logic [HW-1:0]     mem_wdata;
  logic              push;
  logic [BYTE_W-1:0] push_addr;
  status_e           push_status;

  // ---------------------------------------------------------------- datapath
  assign hdr       = rd_init_q ? HdrInit : rd_q;
  assign hdr_size  = hdr[HW-1:1];
  assign hdr_alloc = hdr[0];
  assign size_c    = CW'(hdr_size);
  assign need_c    = CW'(need_q);
  assign fit       = !hdr_alloc && (size_c > need_c);
  assign step_amt  = (hdr_size == '0) ? CW'(1) : size_c;   // zero-size header skips one granule
  assign past_end  = p_q >= HeapEnd;
  assign rest_ptr  = p_q + need_c;
  assign rest_ok   = rest_ptr < HeapEnd;
  assign diff      = size_c - need_c;
  assign p_inc     = p_q + CW'(1);
  assign free_idx  = CW'(addr_q[BYTE_W-1:4]) - CW'(1);
  assign free_bad  = (addr_q[BYTE_W-1:4] == '0) || (free_idx >= HeapEnd);
  assign need_sum  = (BYTE_W+1)'(req_q) + (BYTE_W+1)'(NEED_BIAS);

  // --------------------------------------------------------------- sequencer
  assign uw         = ucode(step_q);
  assign s_tready_o = (uw.act == A_ACCEPT);
  assign s_txn      = s_tvalid_i && s_tready_o;
  assign out_full   = out_valid_q && !m_tready_i;

  always_comb begin
    is_push = 1'b0;
    case (uw.act)
      A_WR_REST, A_FREE_WR, A_PUSH_DONE, A_PUSH_NULL, A_PUSH_OOM: is_push = 1'b1;
      default: is_push = 1'b0;
    endcase
  end

  assign stall = is_push && out_full;

  always_comb begin
    unique case (uw.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_TXN:   take = !s_txn;
      C_IS_FREE:  take = kind_q;
      C_REQ_ZERO: take = (req_q == '0);
      C_PAST_END: take = past_end;
      C_NO_FIT:   take = !fit;
      C_FREE_BAD: take = free_bad;
      default:    take = 1'b0;
    endcase
    if (stall) begin
      step_d = step_q;
    end else if (take) begin
      step_d = uw.target;
    end else begin
      step_d = step_e'(STEP_W'(step_q) + STEP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // ------------------------------------------------------- memory port decode
  always_comb begin
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = p_q[AW-1:0];
    mem_wdata   = hdr;
    push        = 1'b0;
    push_addr   = '0;
    push_status = ST_DONE;
    case (uw.act)
      A_READ: begin
        mem_re = 1'b1;
      end
      A_WR_HEAD: begin
        mem_we    = 1'b1;
        mem_wdata = {need_c[SW-1:0], 1'b1};
      end
      A_WR_REST: begin
        mem_we    = rest_ok && !stall;
        mem_waddr = rest_ptr[AW-1:0];
        mem_wdata = {diff[SW-1:0], 1'b0};
        push      = !stall;
        push_addr = {p_inc[GRAN_W-1:0], 4'b0000};
      end
      A_FREE_WR: begin
        mem_we    = !stall;
        mem_wdata = {hdr[HW-1:1], 1'b0};
        push      = !stall;
      end
      A_PUSH_DONE: push = !stall;
      A_PUSH_NULL: begin
        push        = !stall;
        push_status = ST_NULL;
      end
      A_PUSH_OOM: begin
        push        = !stall;
        push_status = ST_OOM;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q      <= mem[p_q[AW-1:0]];
      rd_init_q <= (p_q == '0) && !hdr0_q;
    end
  end

  // first header reads as the whole free heap until it is written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr0_q <= 1'b0;
    end else if (mem_we && (mem_waddr == '0)) begin
      hdr0_q <= 1'b1;
    end
  end

  // ------------------------------------------------------- payload registers
  always_ff @(posedge clk_i) begin
    if (s_txn) begin
      kind_q <= s_tuser_i;
      req_q  <= s_tdata_i[15:0];
      addr_q <= s_tdata_i[31:16];
    end
  end

  always_ff @(posedge clk_i) begin
    need_q <= need_sum[BYTE_W:4];
    case (uw.act)
      A_PTR_CLEAR: p_q <= '0;
      A_STEP:      if (!fit) p_q <= p_q + step_amt;
      A_FREE_PTR:  p_q <= free_idx;
      default: ;
    endcase
  end

  // ---------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_addr_q   <= push_addr;
      out_status_q <= push_status;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {6'b000000, out_status_q, out_addr_q};

`ifndef SYNTHESIS
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("header memory read and written in the same cycle");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (!out_valid_q || m_tready_i))
    else $error("result register overwritten before it was taken");

  a_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_txn |=> (step_q == S_DISPATCH))
    else $error("accepted request not dispatched");

  a_split_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.act == A_WR_HEAD) |-> (!hdr_alloc && (need_c < size_c)))
    else $error("split of a block that does not fit");
`endif

endmodule

### dv/ffba_tb_pkg.sv
`timescale 1ns / 1ps
package ffba_tb_pkg;

  // Request kind carried on s_tuser
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

endpackage

### dv/ffba_heap_checker.sv
`timescale 1ns / 1ps
module ffba_heap_checker
  import ffba_pkg::*;
  import ffba_tb_pkg::*;
#(
  parameter int HEAP_GRANULES = HEAP_GRANULES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,   // [15:0] request_bytes, [31:16] payload_address
  input  logic        s_tuser_i,   // [0] kind
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [23:0] m_tdata_i,   // [15:0] result_address, [17:16] status
  output int          mismatches_o,
  output int          pending_o
);

  typedef struct packed {
    logic [15:0] addr;
    status_e     status;
  } grant_t;

  logic [13:0] headers [HEAP_GRANULES];   // {size in granules, allocated}
  logic [11:0] walk_stop;
  grant_t      expected_grants [$];

  function automatic grant_t serve_request(input op_e op, input logic [15:0] req_bytes,
                                           input logic [15:0] payload);
    grant_t      g;
    logic [16:0] need;
    logic [12:0] sz;
    logic [11:0] gran;
    int          p;
    g = '{addr: '0, status: ST_DONE};
    if (op == OP_FREE) begin
      // header sits one granule below the payload; low nibble dropped
      gran = payload[15:4];
      if (gran != '0 && int'(gran) - 1 < HEAP_GRANULES) begin
        headers[int'(gran) - 1][0] = 1'b0;
      end
    end else if (req_bytes == '0) begin
      g.status = ST_NULL;
    end else begin
      need = (17'(req_bytes) + 17'(NEED_BIAS)) / 17'(GRANULE_BYTES);
      p    = 0;
      sz   = '0;
      while (p < HEAP_GRANULES) begin
        sz = headers[p][13:1];
        if (!headers[p][0] && 17'(sz) > need) break;
        p += (sz == '0) ? 1 : int'(sz);
      end
      walk_stop = p[11:0];
      if (p >= HEAP_GRANULES) begin
        g.status = ST_OOM;
      end else begin
        headers[p] = {need[12:0], 1'b1};
        if (p + int'(need) < HEAP_GRANULES) begin
          headers[p + int'(need)] = {sz - need[12:0], 1'b0};
        end
        g.addr = 16'((p + 1) * GRANULE_BYTES);
      end
    end
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    if (!rst_ni) begin
      for (int i = 0; i < HEAP_GRANULES; i++) headers[i] = '0;
      headers[0] = {13'(HEAP_GRANULES), 1'b0};
      walk_stop  = '0;
      expected_grants.delete();
      pending_o <= 0;
    end else begin
      // retire before queueing: a result never belongs to a request of the same edge
      if (m_tvalid_i && m_tready_i) begin
        if (expected_grants.size() == 0) begin
          $error("result transaction with nothing outstanding: result_address %0d status %0d",
                 m_tdata_i[15:0], m_tdata_i[17:16]);
          mismatches_o++;
        end else begin
          want = expected_grants.pop_front();
          if (m_tdata_i[15:0] !== want.addr) begin
            $error("result_address: expected %0d, got %0d", want.addr, m_tdata_i[15:0]);
            mismatches_o++;
          end
          if (m_tdata_i[17:16] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tdata_i[17:16]);
            mismatches_o++;
          end
          if (m_tdata_i[23:18] !== '0) begin
            $error("tdata padding: expected 0, got %0h", m_tdata_i[23:18]);
            mismatches_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_grants.push_back(serve_request(op_e'(s_tuser_i), s_tdata_i[15:0],
                                                s_tdata_i[31:16]));
      end
      pending_o <= expected_grants.size();
    end
  end

endmodule

### dv/first_fit_block_allocator_core_test.sv
`timescale 1ns / 1ps
module first_fit_block_allocator_core_test;
  import ffba_pkg::*;
  import ffba_tb_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int PHASE_ITEMS  = 108;

  logic        clk_i;
  logic        rst_ni     = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [31:0] s_tdata_i  = '0;
  logic        s_tuser_i  = 1'b0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [23:0] m_tdata_o;
  int          mismatches;
  int          pending_results;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_requests  = 0;
  // payloads of block starts whose headers are known to be written
  logic [15:0] live_payloads [$] = '{16'd16};
  logic        grant_seen = 1'b0;
  logic [15:0] grant_addr = '0;

  first_fit_block_allocator_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  ffba_heap_checker heap_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid_i),
    .s_tready_i   (s_tready_o),
    .s_tdata_i    (s_tdata_i),
    .s_tuser_i    (s_tuser_i),
    .m_tvalid_i   (m_tvalid_o),
    .m_tready_i   (m_tready_i),
    .m_tdata_i    (m_tdata_o),
    .mismatches_o (mismatches),
    .pending_o    (pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #80_000_000;
    $display("first_fit_block_allocator_core regression: fail");
    $finish;
  end

  // Grants are captured at the edge and added to the pool at the falling edge that follows
  always @(posedge clk_i) begin
    grant_seen <= m_tvalid_o && m_tready_i && m_tdata_o[17:16] == ST_DONE &&
                  m_tdata_o[15:0] != '0;
    grant_addr <= m_tdata_o[15:0];
  end

  always @(negedge clk_i) begin
    if (grant_seen) live_payloads.push_back(grant_addr);
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        repeat (HOLD_CYCLES) begin
          m_tready_i <= 1'b0;
          @(posedge clk_i);
        end
      end
      m_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Returns in the step of the accepting edge with tvalid still high
  task automatic send(input op_e op, input logic [15:0] req_bytes,
                      input logic [15:0] payload);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= op;
    s_tdata_i  <= {payload, req_bytes};
    do @(posedge clk_i); while (!s_tready_o);
  endtask

  task automatic drain();
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  task automatic send_random(output bit effective);
    int          pick;
    int          size_class;
    logic [15:0] req_bytes;
    logic [15:0] payload;
    pick      = $urandom_range(99);
    req_bytes = 16'($urandom);
    payload   = 16'($urandom);
    effective = 1'b1;
    if (pick < 60) begin
      // mostly small blocks so the heap fills late and reuse is exercised
      size_class = $urandom_range(99);
      if (size_class < 80)      req_bytes = 16'($urandom_range(128, 1));
      else if (size_class < 95) req_bytes = 16'($urandom_range(1024, 129));
      else if (size_class < 99) req_bytes = 16'($urandom_range(8192, 1025));
      else                      req_bytes = 16'($urandom_range(65535, 8193));
      send(OP_ALLOC, req_bytes, payload);
    end else if (pick < 90) begin
      payload = live_payloads[$urandom_range(live_payloads.size() - 1)] |
                16'($urandom_range(15));
      send(OP_FREE, req_bytes, payload);
    end else if (pick < 94) begin
      effective = 1'b0;   // header would lie before the heap, dropped by the block
      send(OP_FREE, req_bytes, 16'($urandom_range(15)));
    end else begin
      send(OP_ALLOC, '0, payload);
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input bit hold_off);
    int done_items;
    bit effective;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (hold_off) hold_requests++;
    done_items = 0;
    while (done_items < PHASE_ITEMS) begin
      send_random(effective);
      if (effective) done_items++;
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(OP_ALLOC, 16'd0, 16'hFFFF);       // zero size
    send(OP_FREE, 16'hFFFF, 16'd0);        // header before the heap
    send(OP_FREE, 16'd0, 16'd15);
    send(OP_ALLOC, 16'd1, 16'd0);          // smallest request, two granules
    send(OP_ALLOC, 16'd15, 16'hA5A5);
    send(OP_ALLOC, 16'd16, 16'h5A5A);      // first size needing three granules
    send(OP_ALLOC, 16'hFFFF, 16'd0);       // larger than the heap
    send(OP_ALLOC, 16'd65503, 16'd0);      // only fits an untouched heap
    send(OP_FREE, 16'd0, 16'd31);          // unaligned address, first block
    send(OP_ALLOC, 16'd1, 16'd0);          // free block of exactly the need is passed over
    send(OP_FREE, 16'd0, 16'd16);          // double free
    send(OP_FREE, 16'd0, 16'd80);
    send(OP_ALLOC, 16'd1, 16'hFFFF);       // split leaves a one-granule block
    send(OP_FREE, 16'd0, 16'd117);         // free of a block already free
    send(OP_ALLOC, 16'd17, 16'd0);
    send(OP_ALLOC, 16'd4000, 16'd0);
    send(OP_FREE, 16'd0, 16'd208);
    send(OP_ALLOC, 16'd4015, 16'd0);
    send(OP_ALLOC, 16'd3999, 16'd0);
    drain();

    run_phase(0, 0, 1'b0);
    run_phase(77, 0, 1'b0);
    run_phase(0, 77, 1'b0);
    run_phase(21, 21, 1'b0);
    run_phase(0, 0, 1'b1);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("first_fit_block_allocator_core regression: pass");
    end else begin
      $display("first_fit_block_allocator_core regression: fail");
    end
    $finish;
  end

endmodule
